[rtl/core/aopu_pkg.sv]
// Package for the arc odometry pose update block: widths, CORDIC constants,
// and the shared control struct. No dependencies.
package aopu_pkg;

    localparam int VALUE_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int OFFSET_WIDTH      = 22;
    localparam int IO_WIDTH          = 32;
    localparam int CORDIC_STEPS      = 30;

    localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
    localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
    localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
    localparam logic signed [63:0] GAIN_Q30    = 64'sd652032874;

    localparam logic [1:0] REG_VOFF = 2'd0;
    localparam logic [1:0] REG_HOFF = 2'd1;

    typedef struct packed {
        logic start;
        logic busy;
    } t_unit_ctl;

    function automatic logic signed [63:0] atan_q30(input logic [4:0] idx);
        logic signed [63:0] v;
        begin
            unique case (idx)
                5'd0: v = 64'sd843314857;
                5'd1: v = 64'sd497837829;
                5'd2: v = 64'sd263043837;
                5'd3: v = 64'sd133525159;
                5'd4: v = 64'sd67021687;
                5'd5: v = 64'sd33543516;
                5'd6: v = 64'sd16775851;
                5'd7: v = 64'sd8388437;
                5'd8: v = 64'sd4194283;
                5'd9: v = 64'sd2097149;
                default: v = 64'sd1 <<< (6'd30 - {1'b0, idx});
            endcase
            return v;
        end
    endfunction

endpackage

[rtl/core/aopu_cordic.sv]
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, Q2.30 sine and
// cosine of an angle with FB+1 fraction bits. Depends on aopu_pkg.
module aopu_cordic #(
    parameter int FB = aopu_pkg::FRACTION_BITS_DEF,
    parameter int AW = 50
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [AW-1:0] i_angle,
    output logic                 o_done,
    output logic signed [33:0]   o_sin,
    output logic signed [33:0]   o_cos
);
    import aopu_pkg::*;

    localparam logic signed [AW-1:0] TWO_PI =
        AW'((PI_Q60 + (64'd1 << (57 - FB))) >> (58 - FB));

    logic [2:0]  r_st, n_st;
    logic [5:0]  r_cnt, n_cnt;
    logic signed [AW-1:0] r_r, n_r;
    logic signed [35:0] r_x, n_x, r_y, n_y;
    logic signed [35:0] r_z, n_z;
    logic r_flip, n_flip;
    logic signed [63:0] zw;

    localparam logic [2:0] ST_IDLE = 3'd0, ST_MOD = 3'd1, ST_FOLD = 3'd2,
                           ST_ROT = 3'd3, ST_DONE = 3'd4;

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_r = r_r; n_x = r_x; n_y = r_y;
        n_z = r_z; n_flip = r_flip; zw = 64'(r_r) <<< (29 - FB);
        unique case (r_st)
            ST_IDLE: if (i_start) begin
                n_r = i_angle; n_st = ST_MOD;
            end
            ST_MOD: begin
                // Subtractive reduction: one compare and subtract per cycle.
                if (r_r >= TWO_PI) n_r = r_r - TWO_PI;
                else if (r_r < 0) n_r = r_r + TWO_PI;
                else n_st = ST_FOLD;
            end
            ST_FOLD: begin
                if (zw > PI_Q30) zw = zw - 2 * PI_Q30;
                n_flip = 1'b0;
                if (zw > HALF_PI_Q30) begin zw = zw - PI_Q30; n_flip = 1'b1; end
                else if (zw < -HALF_PI_Q30) begin zw = zw + PI_Q30; n_flip = 1'b1; end
                n_z = 36'(zw); n_x = 36'(GAIN_Q30); n_y = '0; n_cnt = '0;
                n_st = ST_ROT;
            end
            ST_ROT: begin
                if (r_z >= 0) begin
                    n_x = r_x - (r_y >>> r_cnt); n_y = r_y + (r_x >>> r_cnt);
                    n_z = r_z - 36'(atan_q30(r_cnt[4:0]));
                end else begin
                    n_x = r_x + (r_y >>> r_cnt); n_y = r_y - (r_x >>> r_cnt);
                    n_z = r_z + 36'(atan_q30(r_cnt[4:0]));
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(CORDIC_STEPS - 1)) n_st = ST_DONE;
            end
            ST_DONE: n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_cnt <= n_cnt; r_r <= n_r; r_x <= n_x; r_y <= n_y; r_z <= n_z;
        r_flip <= n_flip;
    end

    assign o_done = (r_st == ST_DONE);
    assign o_sin  = r_flip ? -34'(r_y) : 34'(r_y);
    assign o_cos  = r_flip ? -34'(r_x) : 34'(r_x);

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("cordic done held");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DONE) |=> (r_st == ST_IDLE)) else $error("cordic exit");
    a_cnt_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_ROT) |-> (r_cnt < 6'(CORDIC_STEPS))) else $error("cordic count");
endmodule

[rtl/core/aopu_divider.sv]
// Bit-serial restoring divider: |n|<<FB / |d|, one quotient bit per cycle,
// truncated and saturated to VW bits. Depends on aopu_pkg.
module aopu_divider #(
    parameter int VW = aopu_pkg::VALUE_WIDTH_DEF,
    parameter int FB = aopu_pkg::FRACTION_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [VW+1:0] i_num,
    input  logic signed [VW+1:0] i_den,
    output logic                 o_done,
    output logic signed [VW-1:0] o_quo
);
    import aopu_pkg::*;

    localparam int NW = VW + 2 + FB;
    localparam int CW = $clog2(NW + 1);

    logic r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_n, r_q;
    logic [VW+2:0] r_rem, r_d;
    logic r_neg;
    logic [VW+2:0] sh;
    logic [VW+1:0] mn, md;

    assign mn = i_num[VW+1] ? (VW+2)'(-i_num) : i_num;
    assign md = i_den[VW+1] ? (VW+2)'(-i_den) : i_den;
    assign sh = {r_rem[VW+1:0], r_n[NW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1; r_cnt <= CW'(NW);
                r_n <= {mn, FB'(0)}; r_d <= {1'b0, md}; r_rem <= '0; r_q <= '0;
                r_neg <= i_num[VW+1] ^ i_den[VW+1];
            end else if (r_busy) begin
                r_n <= r_n << 1;
                if (sh >= r_d) begin
                    r_rem <= sh - r_d; r_q <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= sh; r_q <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0; r_done <= 1'b1;
                end
            end
        end
    end

    localparam logic [NW-1:0] QMAX = NW'((64'd1 << (VW - 1)) - 64'd1);
    always_comb begin
        if (r_neg) o_quo = (r_q > QMAX + NW'(1)) ? {1'b1, {(VW-1){1'b0}}}
                                                 : VW'(-r_q);
        else o_quo = (r_q > QMAX) ? {1'b0, {(VW-1){1'b1}}} : VW'(r_q);
    end

    assign o_done = r_done;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("div done held");
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy) else $error("div busy at done");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0)) else $error("div count");
endmodule

[rtl/core/aopu_mulround.sv]
// Shift-add multiplier, one bit per cycle: (a*b)>>sh rounded half away from
// zero, sh in {29,30}. Depends on aopu_pkg.
module aopu_mulround #(
    parameter int AW = 50
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [33:0]   i_b,
    input  logic                 i_sh30,
    output logic                 o_done,
    output logic signed [AW+4:0] o_p
);
    import aopu_pkg::*;

    localparam int PW = AW + 34;
    logic r_busy, r_done, r_neg, r_sh30;
    logic [5:0] r_cnt;
    logic [PW-1:0] r_acc, r_ma;
    logic [33:0] r_mb;
    logic [PW-1:0] rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1; r_cnt <= 6'd34; r_acc <= '0;
                r_ma <= PW'(i_a[AW-1] ? AW'(-i_a) : i_a);
                r_mb <= i_b[33] ? 34'(-i_b) : i_b;
                r_neg <= i_a[AW-1] ^ i_b[33]; r_sh30 <= i_sh30;
            end else if (r_busy) begin
                if (r_mb[0]) r_acc <= r_acc + r_ma;
                r_ma <= r_ma << 1; r_mb <= r_mb >> 1;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin r_busy <= 1'b0; r_done <= 1'b1; end
            end
        end
    end

    always_comb begin
        if (r_sh30) rnd = (r_acc + (PW'(1) << 29)) >> 30;
        else        rnd = (r_acc + (PW'(1) << 28)) >> 29;
        o_p = r_neg ? -(AW+5)'(rnd) : (AW+5)'(rnd);
    end
    assign o_done = r_done;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("mul done held");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy) else $error("mul busy at done");
endmodule

[rtl/core/arc_odometry_pose_update.sv]
// Top level of the arc odometry pose update: configuration port, pose state,
// and the sequencer over aopu_cordic, aopu_divider and aopu_mulround.
// Depends on aopu_pkg.
//
//   Channel  | Direction | Signals
//   ---------+-----------+--------------------------------------------------
//   sample   | in        | i_valid / o_ready, wheel distances, gyro rotation
//   pose     | out       | o_valid / i_ready, pose x, pose y, heading
//   config   | in        | APB-style psel/penable/pwrite/paddr/pwdata/prdata
//
// A transaction with a heading change runs two serial divisions, six serial
// multiplies and two CORDIC passes, each of which first reduces its angle by
// one 2*pi turn at a time. Without a heading change the divisions, the first
// CORDIC pass and the first two multiplies are skipped. The shared multiplier
// is the longest part of the loop. Reset is synchronous and clears the
// offsets, wheel history, pose and heading. A finished result waits in the
// output registers; the sample channel stays not ready until the pose
// transaction has been taken.
module arc_odometry_pose_update #(
    parameter int VALUE_WIDTH   = aopu_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = aopu_pkg::FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic signed [aopu_pkg::IO_WIDTH-1:0] i_vertical_distance,
    input  logic signed [aopu_pkg::IO_WIDTH-1:0] i_horizontal_distance,
    input  logic signed [aopu_pkg::IO_WIDTH-1:0] i_gyro_rotation,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [aopu_pkg::IO_WIDTH-1:0] o_pose_x_out,
    output logic signed [aopu_pkg::IO_WIDTH-1:0] o_pose_y_out,
    output logic signed [aopu_pkg::IO_WIDTH-1:0] o_heading_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import aopu_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int AW = VW + 18;   // angle and multiplier operand width
    localparam logic signed [VW+3:0] SMAX = (VW+4)'((64'd1 << (VW - 1)) - 64'd1);
    localparam logic signed [VW+3:0] SMIN = -SMAX - (VW+4)'(1);

    localparam logic [3:0] S_IDLE = 4'd0, S_DIVH = 4'd1, S_DIVV = 4'd2,
        S_CS1 = 4'd3, S_MLX = 4'd4, S_MLY = 4'd5, S_CS2 = 4'd6,
        S_M1 = 4'd7, S_M2 = 4'd8, S_M3 = 4'd9, S_M4 = 4'd10, S_ACC = 4'd11,
        S_OUT = 4'd12;

    // Saturate a wide signed value to VW bits.
    function automatic logic signed [VW-1:0] sat(input logic signed [AW+4:0] v);
        if (v > (AW+5)'(SMAX)) return VW'(SMAX);
        if (v < (AW+5)'(SMIN)) return VW'(SMIN);
        return VW'(v);
    endfunction

    logic signed [OFFSET_WIDTH-1:0] r_voff, r_hoff;
    logic signed [VW-1:0] r_pv, r_ph, r_px, r_py, r_hd, r_nh;
    // The heading change spans twice the heading range, so it needs one more bit.
    logic signed [VW:0] r_dt;
    logic signed [VW-1:0] r_qh, r_qv, r_lx, r_ly;
    logic signed [VW+1:0] r_dv, r_dh;
    logic signed [AW+4:0] r_t1, r_t2;
    logic signed [33:0] r_s, r_c;
    logic [3:0] r_st;
    logic r_valid;

    // Configuration port.
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voff <= '0; r_hoff <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_HOFF[0]) r_hoff <= pwdata[OFFSET_WIDTH-1:0];
            else if (paddr[2] == REG_VOFF[0]) r_voff <= pwdata[OFFSET_WIDTH-1:0];
        end
    end
    assign prdata = paddr[2] ? 32'(r_hoff) : 32'(r_voff);

    // Shared arithmetic units.
    t_unit_ctl cs_ctl, dv_ctl, mu_ctl;
    logic signed [AW-1:0] cs_ang, mu_a;
    logic signed [VW+1:0] dv_num;
    logic signed [33:0] cs_sin, cs_cos, mu_b;
    logic signed [VW-1:0] dv_q;
    logic signed [AW+4:0] mu_p;
    logic cs_done, dv_done, mu_done, mu_sh30;

    aopu_cordic #(.FB(FRACTION_BITS), .AW(AW)) u_cordic (
        .i_clk, .i_rst_n, .i_start(cs_ctl.start), .i_angle(cs_ang),
        .o_done(cs_done), .o_sin(cs_sin), .o_cos(cs_cos));
    aopu_divider #(.VW(VW), .FB(FRACTION_BITS)) u_div (
        .i_clk, .i_rst_n, .i_start(dv_ctl.start), .i_num(dv_num),
        .i_den((VW+2)'(r_dt)), .o_done(dv_done), .o_quo(dv_q));
    aopu_mulround #(.AW(AW)) u_mul (
        .i_clk, .i_rst_n, .i_start(mu_ctl.start), .i_a(mu_a), .i_b(mu_b),
        .i_sh30(mu_sh30), .o_done(mu_done), .o_p(mu_p));

    logic accept, entered;
    logic signed [VW:0] neg_g;
    assign accept = i_valid && o_ready;
    assign o_ready = (r_st == S_IDLE) && !r_valid;
    assign neg_g = -(VW+1)'($signed(i_gyro_rotation));

    // Start pulses are issued in the first cycle that a state is held, flagged by entered.
    always_comb begin
        cs_ctl.busy = 1'b0; dv_ctl.busy = 1'b0; mu_ctl.busy = 1'b0;
        cs_ctl.start = entered && (r_st == S_CS1 || r_st == S_CS2);
        dv_ctl.start = entered && (r_st == S_DIVH || r_st == S_DIVV);
        mu_ctl.start = entered && (r_st >= S_MLX && r_st <= S_M4 && r_st != S_CS2);
        cs_ang = (r_st == S_CS1) ? AW'(r_dt) : (AW'(r_hd) <<< 1) + AW'(r_dt);
        dv_num = (r_st == S_DIVH) ? r_dh : r_dv;
        mu_sh30 = !(r_st == S_MLX || r_st == S_MLY);
        mu_a = AW'(r_lx); mu_b = r_c;
        unique case (r_st)
            S_MLX: begin mu_a = AW'(r_qh) + AW'(r_hoff); mu_b = r_s; end
            S_MLY: begin mu_a = AW'(r_qv) + AW'(r_voff); mu_b = r_s; end
            S_M1:  begin mu_a = AW'(r_lx); mu_b = r_c; end
            S_M2:  begin mu_a = AW'(r_ly); mu_b = r_s; end
            S_M3:  begin mu_a = AW'(r_ly); mu_b = r_c; end
            S_M4:  begin mu_a = AW'(r_lx); mu_b = r_s; end
            default: begin mu_a = AW'(r_lx); mu_b = r_c; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_valid <= 1'b0; entered <= 1'b0;
            r_pv <= '0; r_ph <= '0; r_px <= '0; r_py <= '0; r_hd <= '0;
        end else begin
            entered <= 1'b0;
            if (r_valid && i_ready) r_valid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (accept) begin
                    r_dv <= (VW+2)'($signed(i_vertical_distance)) - (VW+2)'(r_pv);
                    r_dh <= (VW+2)'($signed(i_horizontal_distance)) - (VW+2)'(r_ph);
                    r_pv <= VW'($signed(i_vertical_distance));
                    r_ph <= VW'($signed(i_horizontal_distance));
                    r_nh <= sat((AW+5)'(neg_g));
                    r_dt <= (VW+1)'(sat((AW+5)'(neg_g))) - (VW+1)'(r_hd);
                    r_st <= S_DIVH; entered <= 1'b1;
                end
                S_DIVH: begin
                    if (r_dt == '0) begin
                        r_lx <= sat((AW+5)'(r_dh)); r_ly <= sat((AW+5)'(r_dv));
                        r_st <= S_CS2; entered <= 1'b1;
                    end else if (dv_done) begin
                        r_qh <= dv_q; r_st <= S_DIVV; entered <= 1'b1;
                    end
                end
                S_DIVV: if (dv_done) begin
                    r_qv <= dv_q; r_st <= S_CS1; entered <= 1'b1;
                end
                S_CS1: if (cs_done) begin
                    r_s <= cs_sin; r_c <= cs_cos; r_st <= S_MLX; entered <= 1'b1;
                end
                S_MLX: if (mu_done) begin
                    r_lx <= sat(mu_p); r_st <= S_MLY; entered <= 1'b1;
                end
                S_MLY: if (mu_done) begin
                    r_ly <= sat(mu_p); r_st <= S_CS2; entered <= 1'b1;
                end
                S_CS2: if (cs_done) begin
                    r_s <= cs_sin; r_c <= cs_cos; r_st <= S_M1; entered <= 1'b1;
                end
                S_M1: if (mu_done) begin
                    r_t1 <= mu_p; r_st <= S_M2; entered <= 1'b1;
                end
                S_M2: if (mu_done) begin
                    r_t1 <= r_t1 + mu_p; r_st <= S_M3; entered <= 1'b1;
                end
                S_M3: if (mu_done) begin
                    r_t2 <= mu_p; r_st <= S_M4; entered <= 1'b1;
                end
                S_M4: if (mu_done) begin
                    r_t2 <= r_t2 - mu_p; r_st <= S_ACC;
                end
                S_ACC: begin
                    r_px <= sat((AW+5)'(r_px) + r_t1);
                    r_py <= sat((AW+5)'(r_py) + r_t2);
                    r_hd <= r_nh; r_st <= S_OUT;
                end
                S_OUT: begin
                    r_valid <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_pose_x_out  = IO_WIDTH'(r_px);
    assign o_pose_y_out  = IO_WIDTH'(r_py);
    assign o_heading_out = IO_WIDTH'(r_hd);

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_out_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT) |=> o_valid) else $error("result lost");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pose_x_out)))
        else $error("result dropped");
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({cs_ctl.start, dv_ctl.start, mu_ctl.start}) <= 1)
        else $error("two units started");
endmodule

[sim/tb.sv]
// Testbench for arc_odometry_pose_update: drives sensor samples and register
// writes, predicts every pose transaction in a scoreboard class and checks it.
// Depends on aopu_pkg and the arc_odometry_pose_update RTL.
module tb;
    import aopu_pkg::*;

    // Expected pose and heading of one pose transaction.
    typedef struct {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [31:0] heading;
    } t_pose;

    // Holds a copy of the odometry state and predicts each pose transaction.
    class odometry_scoreboard;
        longint vert_offset, horiz_offset;
        longint last_vert, last_horiz, pos_x, pos_y, head;
        t_pose  pending_poses[$];
        int     errors;
        longint arctan_tbl[CORDIC_STEPS] = '{
            843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
            16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
            65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
            16, 8, 4, 2};

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] d);
            longint v;
            v = longint'(signed'(d[21:0]));
            if (idx == REG_VOFF) vert_offset = v;
            else if (idx == REG_HOFF) horiz_offset = v;
        endfunction

        // Product shifted right by sh, rounded half away from zero.
        function longint scale_round(longint a, longint b, int sh);
            bit neg;
            bit [63:0] ma, mb;
            bit [127:0] p;
            longint r;
            neg = (a < 0) != (b < 0);
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            p = {64'd0, ma} * {64'd0, mb};
            p = (p + (128'd1 << (sh - 1))) >> sh;
            r = longint'(p[63:0]);
            return neg ? -r : r;
        endfunction

        // Fixed-point quotient, truncated toward zero and saturated.
        function longint quotient(longint n, longint d);
            bit neg;
            bit [63:0] mn, md, q;
            neg = (n < 0) != (d < 0);
            mn = (n < 0) ? -n : n;
            md = (d < 0) ? -d : d;
            q = (mn << 16) / md;
            if (neg) return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
            return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
        endfunction

        // Sine and cosine in Q2.30 of an angle carrying 17 fraction bits.
        function void sincos(longint a, output longint s, output longint c);
            longint two_pi, r, z, x, y, xs, ys;
            bit flip;
            two_pi = longint'((PI_Q60 + (64'd1 << 41)) >> 42);
            r = a % two_pi;
            if (r < 0) r += two_pi;
            z = r <<< 13;
            x = GAIN_Q30;
            y = 0;
            flip = 0;
            if (z > PI_Q30) z -= 2 * PI_Q30;
            if (z > HALF_PI_Q30) begin
                z -= PI_Q30;
                flip = 1;
            end else if (z < -HALF_PI_Q30) begin
                z += PI_Q30;
                flip = 1;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys; y += xs; z -= arctan_tbl[i];
                end else begin
                    x += ys; y -= xs; z += arctan_tbl[i];
                end
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endfunction

        function void note_sample(logic signed [31:0] vd, logic signed [31:0] hd,
                                  logic signed [31:0] gy);
            longint dv, dh, nh, dt, lx, ly, s, c, dx, dy;
            t_pose  e;
            dv = longint'(vd) - last_vert;
            dh = longint'(hd) - last_horiz;
            nh = clamp32(-longint'(gy));
            dt = nh - head;
            last_vert = vd;
            last_horiz = hd;
            if (dt == 0) begin
                lx = clamp32(dh);
                ly = clamp32(dv);
            end else begin
                sincos(dt, s, c);
                lx = clamp32(scale_round(quotient(dh, dt) + horiz_offset, s, 29));
                ly = clamp32(scale_round(quotient(dv, dt) + vert_offset, s, 29));
            end
            sincos(2 * head + dt, s, c);
            dx = scale_round(lx, c, 30) + scale_round(ly, s, 30);
            dy = scale_round(ly, c, 30) - scale_round(lx, s, 30);
            pos_x = clamp32(pos_x + dx);
            pos_y = clamp32(pos_y + dy);
            head = nh;
            e.pose_x = pos_x[31:0];
            e.pose_y = pos_y[31:0];
            e.heading = head[31:0];
            pending_poses.push_back(e);
        endfunction

        function void check_pose(logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] h);
            t_pose e;
            if (pending_poses.size() == 0) begin
                $error("pose transaction with no sample outstanding");
                errors++;
                return;
            end
            e = pending_poses.pop_front();
            if (x !== e.pose_x) begin
                $error("pose_x_out expected %0d actual %0d", e.pose_x, x);
                errors++;
            end
            if (y !== e.pose_y) begin
                $error("pose_y_out expected %0d actual %0d", e.pose_y, y);
                errors++;
            end
            if (h !== e.heading) begin
                $error("heading_out expected %0d actual %0d", e.heading, h);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int HOLD_CYCLES    = 3000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic signed [31:0] i_vertical_distance = 0;
    logic signed [31:0] i_horizontal_distance = 0;
    logic signed [31:0] i_gyro_rotation = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic signed [31:0] o_pose_x_out, o_pose_y_out, o_heading_out;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    odometry_scoreboard odo_sb = new();

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_left = 0;
    bit  hold_request = 0;
    bit  hold_taken = 0;
    int  quiet_cycles = 0;
    // Walk state for well-formed sample sequences.
    logic signed [31:0] walk_v = 0, walk_h = 0, walk_g = 0;

    arc_odometry_pose_update i_dut (.*);

    always #4 i_clk = ~i_clk;

    // Receiver: checks each pose transaction and decides ready for the next
    // edge. A hold-off request keeps ready low for a long stretch so that the
    // block fills up and stops taking samples.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                odo_sb.check_pose(o_pose_x_out, o_pose_y_out, o_heading_out);
            if (hold_request && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_left <= HOLD_CYCLES;
                i_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: counts cycles in which no transaction moves on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Register write over the configuration port: setup, then access.
    task automatic reg_write(logic [1:0] idx, logic [31:0] d);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx[0], 2'b00};
        pwdata <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        odo_sb.write_reg(idx, d);
    endtask

    // Offers one sample and returns once its transaction is accepted.
    task automatic send_sample(logic signed [31:0] vd, logic signed [31:0] hd,
                               logic signed [31:0] gy);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_vertical_distance <= vd;
        i_horizontal_distance <= hd;
        i_gyro_rotation <= gy;
        do @(posedge i_clk); while (!o_ready);
        odo_sb.note_sample(vd, hd, gy);
    endtask

    // Signed step of up to about 2^bits in magnitude.
    function automatic logic signed [31:0] rand_step(int bits);
        logic signed [31:0] m;
        m = $urandom_range((1 << bits) - 1);
        return $urandom_range(1) ? m : -m;
    endfunction

    // Mostly smooth motion with random content; some full-range noise.
    // Full-range gyro values are rare since large angles slow the block down.
    task automatic send_random_sample();
        int kind;
        kind = $urandom_range(99);
        if (kind < 75) begin
            walk_v = walk_v + rand_step($urandom_range(4, 20));
            walk_h = walk_h + rand_step($urandom_range(4, 20));
            if ($urandom_range(99) >= 15)
                walk_g = walk_g + rand_step($urandom_range(2, 16));
            if (walk_g > 32'sd1310720 || walk_g < -32'sd1310720)
                walk_g = 0;
            send_sample(walk_v, walk_h, walk_g);
        end else if (kind < 97) begin
            send_sample($urandom, $urandom, rand_step($urandom_range(2, 20)));
        end else begin
            send_sample($urandom, $urandom, $urandom);
        end
    endtask

    // Waits until every pose transaction has been checked, plus some slack.
    task automatic drain();
        while (odo_sb.pending_poses.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed samples with zero offsets: a zero step, counter jumps at
        // the range extremes with no turn, the most negative gyro reading,
        // a repeated heading and small turns both ways.
        send_sample(0, 0, 0);
        send_sample(32'sh7fffffff, 32'sh80000000, 0);
        send_sample(32'sh80000000, 32'sh7fffffff, 0);
        send_sample(32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_sample(0, 0, 32'sh80000000);
        send_sample(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_sample(0, 0, 0);
        send_sample(32'sh10000, 32'sh8000, 32'sh1);
        send_sample(32'sh20000, 32'sh10000, -32'sh1);
        send_sample(32'sh30000, 32'sh18000, 32'sh3243f);
        send_sample(32'sh30000, 32'sh18000, 32'sh3243f);
        send_sample(-32'sh10000, 32'sh7fffffff, -32'sh6487e);
        send_sample(0, 0, 0);
        i_valid <= 1'b0;
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    reg_write(REG_VOFF, 32'h001fffff);
                    reg_write(REG_HOFF, 32'h00200000);
                end
                1: begin
                    send_idle_pct = 61; recv_stall_pct = 0;
                    reg_write(REG_VOFF, 32'h00200000);
                    reg_write(REG_HOFF, 32'h001fffff);
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 61;
                    reg_write(REG_VOFF, $urandom);
                    reg_write(REG_HOFF, $urandom);
                end
                default: begin
                    send_idle_pct = 23; recv_stall_pct = 23;
                    reg_write(REG_VOFF, 32'h0);
                    reg_write(REG_HOFF, $urandom_range(255));
                end
            endcase
            // Directed samples again so each offset setting meets both
            // extremes of the wheel counters while turning.
            send_sample(32'sh7fffffff, 32'sh80000000, 32'sh4000);
            send_sample(32'sh80000000, 32'sh7fffffff, -32'sh4000);
            for (int n = 0; n < 430; n++) begin
                if (phase == 0 && n == 100)
                    hold_request = 1'b1;
                send_random_sample();
            end
            i_valid <= 1'b0;
            drain();
        end

        if (odo_sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
